@@ rtl/core/rmbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Route message byte parser package
// Item types, record kinds, status codes and register indexes shared by the
// parser and its environment.
// ----------------------------------------------------------------------------
package rmbp_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MAGIC   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 1'b1;

   // Record kinds of a result item.
   localparam logic [2:0] KIND_BASE     = 3'd0;
   localparam logic [2:0] KIND_POINT    = 3'd1;
   localparam logic [2:0] KIND_MANEUVER = 3'd2;
   localparam logic [2:0] KIND_INSTR    = 3'd3;
   localparam logic [2:0] KIND_ROAD     = 3'd4;
   localparam logic [2:0] KIND_FINAL    = 3'd5;

   // Status codes of a final record.
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_BAD_MAGIC   = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED   = 3'd3;
   localparam logic [2:0] STATUS_NO_POINTS   = 3'd4;

   // One input item: a message byte and its end flag.
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       end_of_message;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [2:0]         record_kind;
      logic [2:0]         status;
      logic signed [31:0] latitude_raw;
      logic signed [31:0] longitude_raw;
      logic [15:0]        point_index;
      logic [31:0]        distance_m;
      logic [31:0]        duration_s;
      logic [7:0]         type_code;
      logic [7:0]         modifier_code;
      logic [7:0]         text_byte;
   } rsp_item_type;

endpackage

@@ rtl/core/route_message_byte_parser.sv @@
// ----------------------------------------------------------------------------
// Route message byte parser
// Parses a little-endian route message one byte per item, checks magic and
// version, and emits base, points, maneuvers, text bytes and a final record.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                             Direction  Moves
//   req      req_valid/req_ready/req_data      in         one message byte
//   rsp      rsp_valid/rsp_ready/rsp_data      out        one record
//   csr      csr_we/csr_index/csr_wdata        in         register write
//
// Each byte is decoded in the cycle it is accepted and its record, if any, is
// loaded into the result register, on rsp the next cycle; one item per cycle.
// A new byte is taken whenever the result register is empty or being emptied.
// Synchronous reset clears parse state, CSRs and rsp_valid, not rsp_data.
// A stall on rsp holds the result register and lowers req_ready.
// ----------------------------------------------------------------------------
module route_message_byte_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rmbp_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rmbp_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_we,
   input  logic [rmbp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rmbp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [4:0] {
      PH_MAGIC, PH_VERSION, PH_FLAGS, PH_BASE_LAT, PH_BASE_LNG, PH_PT_COUNT,
      PH_PT_LAT, PH_PT_LNG, PH_MV_COUNT, PH_MV_INDEX, PH_MV_DIST, PH_MV_CODES,
      PH_INSTR_LEN, PH_INSTR_TEXT, PH_ROAD_LEN, PH_ROAD_TEXT, PH_TOTAL_DIST,
      PH_TOTAL_DUR, PH_SKIP
   } phase_type;

   // Number of bytes in the field that a phase reads.
   function automatic logic [2:0] field_bytes(input phase_type ph);
      logic [2:0] n;
      unique case (ph)
         PH_VERSION, PH_FLAGS: n = 3'd1;
         PH_MAGIC, PH_PT_COUNT, PH_MV_COUNT, PH_MV_INDEX, PH_MV_CODES,
         PH_INSTR_LEN, PH_ROAD_LEN: n = 3'd2;
         default: n = 3'd4;
      endcase
      return n;
   endfunction

   phase_type              phase_ff, phase_in;
   logic [1:0]             pos_ff, pos_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            saved_lat_ff, saved_lat_in;
   logic [15:0]            points_left_ff, points_left_in;
   logic [15:0]            mv_left_ff, mv_left_in;
   logic [15:0]            text_left_ff, text_left_in;
   logic [15:0]            held_index_ff, held_index_in;
   logic [31:0]            held_dist_ff, held_dist_in;
   logic [31:0]            total_dist_ff, total_dist_in;
   logic                   any_point_ff, any_point_in;
   logic [15:0]            magic_ff, magic_in;
   logic [7:0]             version_ff, version_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rmbp_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic [7:0]             b;
   logic                   eom;
   logic [31:0]            acc_next;
   logic                   field_done;
   logic                   rec;
   logic                   fin;
   logic [15:0]            mv_dec;
   logic [15:0]            text_dec;
   logic [15:0]            points_dec;
   rmbp_pkg::rsp_item_type res;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_data.msg_byte;
   assign eom       = req_data.end_of_message;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Byte lane merge into the field accumulator.
   assign acc_next   = (pos_ff == 2'd0) ? {24'd0, b}
                     : (acc_ff | ({24'd0, b} << {pos_ff, 3'b000}));
   assign field_done = ({1'b0, pos_ff} + 3'd1) == field_bytes(phase_ff);
   assign mv_dec     = mv_left_ff - 16'd1;
   assign text_dec   = text_left_ff - 16'd1;
   assign points_dec = points_left_ff - 16'd1;

   // Parse step for one accepted item.
   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      acc_in         = acc_ff;
      saved_lat_in   = saved_lat_ff;
      points_left_in = points_left_ff;
      mv_left_in     = mv_left_ff;
      text_left_in   = text_left_ff;
      held_index_in  = held_index_ff;
      held_dist_in   = held_dist_ff;
      total_dist_in  = total_dist_ff;
      any_point_in   = any_point_ff;
      rec            = 1'b0;
      fin            = 1'b0;
      res            = '0;

      if (req_fire) begin
         if (phase_ff == PH_SKIP) begin
            if (eom) begin
               phase_in = PH_MAGIC;
               pos_in   = 2'd0;
            end
         end else begin
            if (phase_ff == PH_INSTR_TEXT || phase_ff == PH_ROAD_TEXT) begin
               // Text bytes pass straight through, one record each.
               res.record_kind = (phase_ff == PH_ROAD_TEXT) ? rmbp_pkg::KIND_ROAD
                                                            : rmbp_pkg::KIND_INSTR;
               res.text_byte   = b;
               rec             = 1'b1;
               text_left_in    = text_dec;
               if (text_dec == 16'd0) begin
                  if (phase_ff == PH_ROAD_TEXT) begin
                     mv_left_in = mv_dec;
                     phase_in   = (mv_dec != 16'd0) ? PH_MV_INDEX : PH_TOTAL_DIST;
                  end else begin
                     phase_in = PH_ROAD_LEN;
                  end
               end
            end else begin
               acc_in = acc_next;
               if (!field_done) begin
                  pos_in = pos_ff + 2'd1;
               end else begin
                  pos_in = 2'd0;
                  // A complete field acts according to the phase.
                  unique case (phase_ff)
                     PH_MAGIC: begin
                        if (acc_next[15:0] != magic_ff) begin
                           res.record_kind = rmbp_pkg::KIND_FINAL;
                           res.status      = rmbp_pkg::STATUS_BAD_MAGIC;
                           fin             = 1'b1;
                        end else begin
                           phase_in = PH_VERSION;
                        end
                     end
                     PH_VERSION: begin
                        if (acc_next[7:0] != version_ff) begin
                           res.record_kind = rmbp_pkg::KIND_FINAL;
                           res.status      = rmbp_pkg::STATUS_BAD_VERSION;
                           fin             = 1'b1;
                        end else begin
                           phase_in = PH_FLAGS;
                        end
                     end
                     PH_FLAGS: phase_in = PH_BASE_LAT;
                     PH_BASE_LAT: begin
                        saved_lat_in = acc_next;
                        phase_in     = PH_BASE_LNG;
                     end
                     PH_PT_LAT: begin
                        saved_lat_in = acc_next;
                        phase_in     = PH_PT_LNG;
                     end
                     PH_BASE_LNG: begin
                        res.record_kind   = rmbp_pkg::KIND_BASE;
                        res.latitude_raw  = $signed(saved_lat_ff);
                        res.longitude_raw = $signed(acc_next);
                        rec               = 1'b1;
                        phase_in          = PH_PT_COUNT;
                     end
                     PH_PT_COUNT: begin
                        points_left_in = acc_next[15:0];
                        any_point_in   = acc_next[15:0] != 16'd0;
                        phase_in       = (acc_next[15:0] != 16'd0) ? PH_PT_LAT
                                                                   : PH_MV_COUNT;
                     end
                     PH_PT_LNG: begin
                        res.record_kind   = rmbp_pkg::KIND_POINT;
                        res.latitude_raw  = $signed(saved_lat_ff);
                        res.longitude_raw = $signed(acc_next);
                        rec               = 1'b1;
                        points_left_in    = points_dec;
                        phase_in = (points_dec != 16'd0) ? PH_PT_LAT : PH_MV_COUNT;
                     end
                     PH_MV_COUNT: begin
                        mv_left_in = acc_next[15:0];
                        phase_in   = (acc_next[15:0] != 16'd0) ? PH_MV_INDEX
                                                               : PH_TOTAL_DIST;
                     end
                     PH_MV_INDEX: begin
                        held_index_in = acc_next[15:0];
                        phase_in      = PH_MV_DIST;
                     end
                     PH_MV_DIST: begin
                        held_dist_in = acc_next;
                        phase_in     = PH_MV_CODES;
                     end
                     PH_MV_CODES: begin
                        res.record_kind   = rmbp_pkg::KIND_MANEUVER;
                        res.point_index   = held_index_ff;
                        res.distance_m    = held_dist_ff;
                        res.type_code     = acc_next[7:0];
                        res.modifier_code = acc_next[15:8];
                        rec               = 1'b1;
                        phase_in          = PH_INSTR_LEN;
                     end
                     PH_INSTR_LEN: begin
                        text_left_in = acc_next[15:0];
                        phase_in     = (acc_next[15:0] != 16'd0) ? PH_INSTR_TEXT
                                                                 : PH_ROAD_LEN;
                     end
                     PH_ROAD_LEN: begin
                        text_left_in = acc_next[15:0];
                        if (acc_next[15:0] != 16'd0) begin
                           phase_in = PH_ROAD_TEXT;
                        end else begin
                           mv_left_in = mv_dec;
                           phase_in = (mv_dec != 16'd0) ? PH_MV_INDEX : PH_TOTAL_DIST;
                        end
                     end
                     PH_TOTAL_DIST: begin
                        total_dist_in = acc_next;
                        phase_in      = PH_TOTAL_DUR;
                     end
                     PH_TOTAL_DUR: begin
                        res.record_kind = rmbp_pkg::KIND_FINAL;
                        res.status      = any_point_ff ? rmbp_pkg::STATUS_OK
                                                       : rmbp_pkg::STATUS_NO_POINTS;
                        res.distance_m  = total_dist_ff;
                        res.duration_s  = acc_next;
                        fin             = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end

            // A finished message or an error wins over the end flag;
            // an early end flag turns the item into a truncated final record.
            if (fin) begin
               phase_in = eom ? PH_MAGIC : PH_SKIP;
               pos_in   = 2'd0;
               rec      = 1'b1;
            end else if (eom) begin
               res             = '0;
               res.record_kind = rmbp_pkg::KIND_FINAL;
               res.status      = rmbp_pkg::STATUS_TRUNCATED;
               phase_in        = PH_MAGIC;
               pos_in          = 2'd0;
               rec             = 1'b1;
            end
         end
      end
   end

   // Configuration writes.
   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      if (csr_we) begin
         unique case (csr_index)
            rmbp_pkg::CSR_EXPECTED_MAGIC:   magic_in   = csr_wdata;
            rmbp_pkg::CSR_EXPECTED_VERSION: version_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Result register with its valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && rec) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   // State, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAGIC;
         pos_ff         <= 2'd0;
         acc_ff         <= '0;
         saved_lat_ff   <= '0;
         points_left_ff <= '0;
         mv_left_ff     <= '0;
         text_left_ff   <= '0;
         held_index_ff  <= '0;
         held_dist_ff   <= '0;
         total_dist_ff  <= '0;
         any_point_ff   <= 1'b0;
         magic_ff       <= '0;
         version_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         acc_ff         <= acc_in;
         saved_lat_ff   <= saved_lat_in;
         points_left_ff <= points_left_in;
         mv_left_ff     <= mv_left_in;
         text_left_ff   <= text_left_in;
         held_index_ff  <= held_index_in;
         held_dist_ff   <= held_dist_in;
         total_dist_ff  <= total_dist_in;
         any_point_ff   <= any_point_in;
         magic_ff       <= magic_in;
         version_ff     <= version_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A stalled result blocks new items.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("item accepted while result stalled");

   // Only final records carry a status.
   a_status_final_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.record_kind != rmbp_pkg::KIND_FINAL)
         |-> rsp_data.status == rmbp_pkg::STATUS_OK)
      else $error("status on a non-final record");

   // An end flag always restarts parsing at the magic.
   a_eom_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && eom) |=> (phase_ff == PH_MAGIC && pos_ff == 2'd0))
      else $error("end flag did not restart the parser");

   // Text phases are entered only with bytes left to pass.
   a_text_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_INSTR_TEXT || phase_ff == PH_ROAD_TEXT)
         |-> text_left_ff != 16'd0)
      else $error("text phase with empty length");

   // Point phases are entered only with points left.
   a_points_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PT_LAT || phase_ff == PH_PT_LNG) |-> points_left_ff != 16'd0)
      else $error("point phase with no points left");
`endif

endmodule
